[sv/gpio_ed_pkg.sv]
// Package for the GPIO controller with edge detection.
// Holds the item types, action codes and register word offsets.
// No dependencies.
`default_nettype none

package gpio_ed_pkg;

  // Pin count and word geometry
  localparam int NUM_PINS  = 54;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 6;
  localparam int FUNC_W    = 3;
  localparam int PULL_W    = 2;
  localparam int FSEL_PINS = 10;

  // Item actions
  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NOP    = 2'd3
  } act_e;

  // Register word offsets
  localparam logic [IDX_W-1:0] OFS_FSEL_LAST = 6'd6;
  localparam logic [IDX_W-1:0] OFS_SET       = 6'd7;
  localparam logic [IDX_W-1:0] OFS_CLR       = 6'd10;
  localparam logic [IDX_W-1:0] OFS_LEV       = 6'd13;
  localparam logic [IDX_W-1:0] OFS_EDS       = 6'd16;
  localparam logic [IDX_W-1:0] OFS_REN       = 6'd19;
  localparam logic [IDX_W-1:0] OFS_FEN       = 6'd22;
  localparam logic [IDX_W-1:0] OFS_PUD       = 6'd37;
  localparam logic [IDX_W-1:0] OFS_PUDCLK    = 6'd38;

  // Pull codes
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

  // Function code that drives the pin
  localparam logic [FUNC_W-1:0] FUNC_OUTPUT = 3'd1;

  typedef struct packed {
    act_e                action;
    logic [IDX_W-1:0]    reg_index;
    logic [WORD_W-1:0]   write_data;
    logic [NUM_PINS-1:0] pad_levels;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]   read_data;
    logic [NUM_PINS-1:0] drive_levels;
    logic [NUM_PINS-1:0] drive_enables;
    logic [NUM_PINS-1:0] pull_ups;
    logic [NUM_PINS-1:0] pull_downs;
    logic                event_any;
  } rsp_t;

endpackage

`default_nettype wire

[sv/gpio_controller_edge_detect_unit.sv]
// Top level of the GPIO controller with edge detection.
// Depends on gpio_ed_pkg for item types, action codes and offsets.
//
//   channel | signals                        | direction | carries
//   cmd     | cmd_valid, cmd_ready, cmd      | in        | read, write, pad sample or nop
//   rsp     | rsp_valid, rsp_ready, rsp      | out       | one result per item
//
// Each item updates the registers in the cycle it is accepted and its result
// lands in a two-entry result queue, visible the next cycle: one item per cycle.
// cmd_ready drops only when both queue entries hold untaken results.
// rst is synchronous and clears all register state and the queue.
// A stalled rsp side holds the result; cmd keeps flowing until the queue fills.
`default_nettype none

module gpio_controller_edge_detect_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  gpio_ed_pkg::cmd_t   cmd,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output gpio_ed_pkg::rsp_t   rsp
);
  import gpio_ed_pkg::*;

  localparam int HI_W = NUM_PINS - WORD_W;

  // Pin vector bits covered by word w of a register pair
  function automatic logic [NUM_PINS-1:0] word_bits(input logic [WORD_W-1:0] d,
                                                    input logic w);
    logic [NUM_PINS-1:0] r;
    r = '0;
    if (w) begin
      r[NUM_PINS-1:WORD_W] = d[HI_W-1:0];
    end else begin
      r[WORD_W-1:0] = d;
    end
    return r;
  endfunction

  // Word w of a pin vector, upper bits zero
  function automatic logic [WORD_W-1:0] get_word(input logic [NUM_PINS-1:0] v,
                                                 input logic w);
    logic [WORD_W-1:0] r;
    r = '0;
    if (w) begin
      r[HI_W-1:0] = v[NUM_PINS-1:WORD_W];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Register state
  logic [NUM_PINS-1:0][FUNC_W-1:0] func, func_next;
  logic [NUM_PINS-1:0][PULL_W-1:0] pull_state, pull_state_next;
  logic [NUM_PINS-1:0] latch, latch_next;
  logic [NUM_PINS-1:0] pads, pads_next;
  logic [NUM_PINS-1:0] eds, eds_next;
  logic [NUM_PINS-1:0] ren, ren_next;
  logic [NUM_PINS-1:0] fen, fen_next;
  logic [PULL_W-1:0]   pull_ctl, pull_ctl_next;

  // Result queue
  rsp_t        q_mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  rsp_t        result;
  logic        push, pop;

  assign cmd_ready = (count != 2'd2);
  assign push      = cmd_valid && cmd_ready;
  assign rsp_valid = (count != 2'd0);
  assign pop       = rsp_valid && rsp_ready;
  assign rsp       = q_mem[rd_ptr];

  // Decoded pair hits and word select
  logic idx_lo, idx_fsel;
  logic [IDX_W-1:0] idx;
  logic [WORD_W-1:0] wd;
  assign idx      = cmd.reg_index;
  assign wd       = cmd.write_data;
  assign idx_fsel = (idx <= OFS_FSEL_LAST);
  assign idx_lo   = 1'b0;

  function automatic logic pair_hit(input logic [IDX_W-1:0] i,
                                    input logic [IDX_W-1:0] base);
    return (i == base) || (i == base + 6'd1);
  endfunction

  function automatic logic pair_w(input logic [IDX_W-1:0] i,
                                  input logic [IDX_W-1:0] base);
    return (i == base + 6'd1);
  endfunction

  // Next state
  always_comb begin
    logic [NUM_PINS-1:0] hit;
    logic [NUM_PINS-1:0] rise, fall;
    func_next       = func;
    pull_state_next = pull_state;
    latch_next      = latch;
    pads_next       = pads;
    eds_next        = eds;
    ren_next        = ren;
    fen_next        = fen;
    pull_ctl_next   = pull_ctl;
    hit             = '0;
    rise            = ~pads & cmd.pad_levels & ren;
    fall            = pads & ~cmd.pad_levels & fen;
    if (push) begin
      case (cmd.action)
        ACT_WRITE: begin
          if (idx_fsel) begin
            for (int r = 0; r <= int'(OFS_FSEL_LAST); r++) begin
              for (int k = 0; k < FSEL_PINS; k++) begin
                if ((r * FSEL_PINS + k < NUM_PINS) && (idx == IDX_W'(r))) begin
                  func_next[r * FSEL_PINS + k] = wd[FUNC_W*k +: FUNC_W];
                end
              end
            end
          end else if (pair_hit(idx, OFS_SET)) begin
            latch_next = latch | word_bits(wd, pair_w(idx, OFS_SET));
          end else if (pair_hit(idx, OFS_CLR)) begin
            latch_next = latch & ~word_bits(wd, pair_w(idx, OFS_CLR));
          end else if (pair_hit(idx, OFS_EDS)) begin
            eds_next = eds & ~word_bits(wd, pair_w(idx, OFS_EDS));
          end else if (pair_hit(idx, OFS_REN)) begin
            ren_next = (ren & ~word_bits(WORD_W'('1), pair_w(idx, OFS_REN)))
                     | word_bits(wd, pair_w(idx, OFS_REN));
          end else if (pair_hit(idx, OFS_FEN)) begin
            fen_next = (fen & ~word_bits(WORD_W'('1), pair_w(idx, OFS_FEN)))
                     | word_bits(wd, pair_w(idx, OFS_FEN));
          end else if (idx == OFS_PUD) begin
            pull_ctl_next = wd[PULL_W-1:0];
          end else if (pair_hit(idx, OFS_PUDCLK)) begin
            hit = word_bits(wd, pair_w(idx, OFS_PUDCLK));
            for (int p = 0; p < NUM_PINS; p++) begin
              if (hit[p]) begin
                pull_state_next[p] = pull_ctl;
              end
            end
          end
        end
        ACT_SAMPLE: begin
          eds_next  = eds | rise | fall;
          pads_next = cmd.pad_levels;
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the accepted item, from the state after it
  always_comb begin
    logic [WORD_W-1:0] rd;
    rd = '0;
    if (cmd.action == ACT_READ) begin
      if (idx_fsel) begin
        for (int r = 0; r <= int'(OFS_FSEL_LAST); r++) begin
          for (int k = 0; k < FSEL_PINS; k++) begin
            if ((r * FSEL_PINS + k < NUM_PINS) && (idx == IDX_W'(r))) begin
              rd[FUNC_W*k +: FUNC_W] = func[r * FSEL_PINS + k];
            end
          end
        end
      end else if (pair_hit(idx, OFS_LEV)) begin
        rd = get_word(pads, pair_w(idx, OFS_LEV));
      end else if (pair_hit(idx, OFS_EDS)) begin
        rd = get_word(eds, pair_w(idx, OFS_EDS));
      end else if (pair_hit(idx, OFS_REN)) begin
        rd = get_word(ren, pair_w(idx, OFS_REN));
      end else if (pair_hit(idx, OFS_FEN)) begin
        rd = get_word(fen, pair_w(idx, OFS_FEN));
      end else if (idx == OFS_PUD) begin
        rd = {{(WORD_W-PULL_W){idx_lo}}, pull_ctl};
      end
    end
    result.read_data    = rd;
    result.drive_levels = latch_next;
    for (int p = 0; p < NUM_PINS; p++) begin
      result.drive_enables[p] = (func_next[p] == FUNC_OUTPUT);
      result.pull_ups[p]      = (pull_state_next[p] == PULL_UP);
      result.pull_downs[p]    = (pull_state_next[p] == PULL_DOWN);
    end
    result.event_any = |eds_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      func       <= '0;
      pull_state <= '0;
      latch      <= '0;
      pads       <= '0;
      eds        <= '0;
      ren        <= '0;
      fen        <= '0;
      pull_ctl   <= '0;
    end else begin
      func       <= func_next;
      pull_state <= pull_state_next;
      latch      <= latch_next;
      pads       <= pads_next;
      eds        <= eds_next;
      ren        <= ren_next;
      fen        <= fen_next;
      pull_ctl   <= pull_ctl_next;
    end
  end

  // Result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= result;
    end
  end

endmodule

`default_nettype wire
